[hw/rtl/block_rms_meter_core_defines.svh]
// Assertion macros used by the RMS meter core.
`ifndef BLOCK_RMS_METER_CORE_DEFINES_SVH
`define BLOCK_RMS_METER_CORE_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define BRM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition implies another one in the same cycle.
`define BRM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that a condition implies another one in the next cycle.
`define BRM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/brm_pkg.sv]
package brm_pkg;

   // Fixed widths of the result fields.
   localparam int RMS_W  = 16;
   localparam int USED_W = 13;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;     // A sample word is taken this cycle.
      logic div_load;   // Load the divider from the final sum.
      logic div_step;   // One quotient bit.
      logic sqrt_step;  // One root bit.
      logic out_load;   // Capture the result and clear the accumulators.
   } brm_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic step_last;  // The current iteration is the final one.
   } brm_stat_type;

endpackage

[hw/rtl/brm_req_if.sv]
interface brm_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          last_sample;

   modport source (output valid, output sample, output last_sample, input ready);
   modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

[hw/rtl/brm_rsp_if.sv]
interface brm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [brm_pkg::RMS_W-1:0]    rms;
   logic [brm_pkg::USED_W-1:0]   samples_used;
   logic                         overflowed;

   modport source (output valid, output rms, output samples_used, output overflowed,
                   input ready);
   modport sink   (input valid, input rms, input samples_used, input overflowed,
                   output ready);
endinterface

[hw/rtl/block_rms_meter_core.sv]
// Non-final samples are taken one per cycle; the square lands in the sum in the following cycle.
// A final sample starts the result: a flush state, a divider state producing SQ_W quotient
// bits and a root state producing SQ_W/2 root bits (SQ_W is the sum width rounded up to
// even, 46 at default), then an output state that waits until the previous word is taken.
// The divider and root loop are bit-serial; no sample is taken meanwhile.
// Synchronous active-high reset clears the sums, count, overflow flag and output valid.
`include "block_rms_meter_core_defines.svh"

module block_rms_meter_core #(
   parameter int MAX_SAMPLES = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input logic       clock,
   input logic       reset,
   brm_req_if.sink   req_bus,
   brm_rsp_if.source rsp_bus
);
   import brm_pkg::*;

   brm_cmd_type  cmd;
   brm_stat_type stat;

   // Sequencer.
   brm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_last  (req_bus.last_sample),
      .req_ready (req_bus.ready),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Accumulator, divider, root and output register.
   brm_datapath #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_sample       (req_bus.sample),
      .rsp_rms          (rsp_bus.rms),
      .rsp_samples_used (rsp_bus.samples_used),
      .rsp_overflowed   (rsp_bus.overflowed)
   );

   // No sample may be taken while a result is being computed.
   `BRM_ASSERT_IMPLY(a_no_accept_busy, clock, reset, cmd.div_step || cmd.sqrt_step, !req_bus.ready, "sample taken during result computation")
   // A result must never overwrite a word the sink has not taken.
   `BRM_ASSERT_IMPLY(a_no_overwrite, clock, reset, cmd.out_load, !rsp_bus.valid || rsp_bus.ready, "output word overwritten")
   // A captured result is offered in the following cycle.
   `BRM_ASSERT_NEXT(a_out_valid, clock, reset, cmd.out_load, rsp_bus.valid, "captured result not offered")
   // At most one of the divider, root and output commands is active at a time.
   `BRM_ASSERT(a_one_cmd, clock, reset, $onehot0({cmd.div_load, cmd.div_step, cmd.sqrt_step, cmd.out_load}), "conflicting datapath commands")

endmodule

[hw/rtl/brm_ctrl.sv]
module brm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_last,
   output logic                  req_ready,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output brm_pkg::brm_cmd_type  cmd,
   input  brm_pkg::brm_stat_type stat
);
   import brm_pkg::*;

   localparam logic [2:0] ST_ACCUM = 3'd0;
   localparam logic [2:0] ST_FLUSH = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_SQRT  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Samples are taken only while accumulating.
   assign req_ready = (state_ff == ST_ACCUM);
   assign rsp_valid = rsp_valid_ff;

   // Command decode.
   always_comb begin
      cmd.accept    = (state_ff == ST_ACCUM) && req_valid;
      cmd.div_load  = (state_ff == ST_FLUSH);
      cmd.div_step  = (state_ff == ST_DIV);
      cmd.sqrt_step = (state_ff == ST_SQRT);
      cmd.out_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_ACCUM: begin
            if (cmd.accept && req_last) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (stat.step_last) state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (stat.step_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (cmd.out_load) state_in = ST_ACCUM;
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   // The output word stays valid until the sink takes it.
   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hw/rtl/brm_datapath.sv]
module brm_datapath #(
   parameter int MAX_SAMPLES = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  brm_pkg::brm_cmd_type          cmd,
   output brm_pkg::brm_stat_type         stat,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic [brm_pkg::RMS_W-1:0]     rsp_rms,
   output logic [brm_pkg::USED_W-1:0]    rsp_samples_used,
   output logic                          rsp_overflowed
);
   import brm_pkg::*;

   localparam int TALLY_W  = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_FULL = 2 * SAMPLE_BITS + TALLY_W;
   localparam int SUM_W    = (SUM_FULL > 64) ? 64 : SUM_FULL;
   localparam int SQ_W     = SUM_W + (SUM_W % 2);
   localparam int ROOT_W   = SQ_W / 2;
   localparam int CNT_W    = $clog2(SQ_W);
   localparam int PROD_W   = 2 * SAMPLE_BITS;
   localparam logic [TALLY_W-1:0] MAX_TALLY = TALLY_W'(MAX_SAMPLES);

   logic [SAMPLE_BITS-1:0] raw;
   logic [SAMPLE_BITS-1:0] mag;
   logic [PROD_W-1:0]      sq_ff;
   logic                   sq_vld_ff;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [TALLY_W-1:0]     tally_ff;
   logic                   ovf_ff;
   logic                   has_room;

   logic [SQ_W-1:0]        quo_ff;
   logic [TALLY_W-1:0]     rem_ff;
   logic [TALLY_W:0]       d_trial;
   logic                   d_ge;
   logic [ROOT_W-1:0]      root_ff;
   logic [ROOT_W+1:0]      srem_ff;
   logic [ROOT_W+1:0]      s_cand;
   logic [ROOT_W+1:0]      s_trial;
   logic                   s_ge;
   logic [CNT_W-1:0]       cnt_ff;

   logic [RMS_W-1:0]       rms_ff;
   logic [USED_W-1:0]      used_ff;
   logic                   ovf_out_ff;

   // Magnitude of the sample; the most negative code maps to its positive value.
   assign raw      = req_sample;
   assign mag      = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;
   assign has_room = (tally_ff < MAX_TALLY);

   // The square is registered and added to the sum in the following cycle.
   assign sum_in = sq_vld_ff ? (sum_ff + SUM_W'(sq_ff)) : sum_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept && has_room) begin
         sq_ff <= mag * mag;
      end
   end

   // Accumulator state, cleared when the result is captured.
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff <= 1'b0;
         sum_ff    <= '0;
         tally_ff  <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         sq_vld_ff <= cmd.accept && has_room;
         if (cmd.out_load) begin
            sum_ff   <= '0;
            tally_ff <= '0;
            ovf_ff   <= 1'b0;
         end else begin
            sum_ff <= sum_in;
            if (cmd.accept && has_room) tally_ff <= tally_ff + TALLY_W'(1);
            if (cmd.accept && !has_room) ovf_ff <= 1'b1;
         end
      end
   end

   // Restoring divider step: one quotient bit shifts into the quotient register.
   assign d_trial = {rem_ff, quo_ff[SQ_W-1]};
   assign d_ge    = (d_trial >= {1'b0, tally_ff});

   // Square root step: two dividend bits leave the top of the quotient register.
   assign s_cand  = {srem_ff[ROOT_W-1:0], quo_ff[SQ_W-1 -: 2]};
   assign s_trial = {root_ff, 2'b01};
   assign s_ge    = (s_cand >= s_trial);

   assign stat.step_last = (cnt_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         quo_ff  <= SQ_W'(sum_in);
         rem_ff  <= '0;
         root_ff <= '0;
         srem_ff <= '0;
         cnt_ff  <= CNT_W'(SQ_W - 1);
      end else if (cmd.div_step) begin
         rem_ff <= d_ge ? TALLY_W'(d_trial - {1'b0, tally_ff}) : d_trial[TALLY_W-1:0];
         quo_ff <= {quo_ff[SQ_W-2:0], d_ge};
         cnt_ff <= (cnt_ff == '0) ? CNT_W'(ROOT_W - 1) : cnt_ff - CNT_W'(1);
      end else if (cmd.sqrt_step) begin
         srem_ff <= s_ge ? (s_cand - s_trial) : s_cand;
         root_ff <= {root_ff[ROOT_W-2:0], s_ge};
         quo_ff  <= {quo_ff[SQ_W-3:0], 2'b00};
         cnt_ff  <= cnt_ff - CNT_W'(1);
      end
   end

   // Output register; an empty count reads as zero.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rms_ff     <= (tally_ff == '0) ? '0 : RMS_W'(root_ff);
         used_ff    <= USED_W'(tally_ff);
         ovf_out_ff <= ovf_ff;
      end
   end

   assign rsp_rms          = rms_ff;
   assign rsp_samples_used = used_ff;
   assign rsp_overflowed   = ovf_out_ff;

endmodule
